// ===== rtl/sha_strm_pkg.sv =====
// Package with the item types, control structs and SHA-256 functions of the stream hasher.
`timescale 1ns / 1ps

package sha_strm_pkg;

    // Input item: one message byte with its flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_item_t;

    // Result item: one digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_result_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUTPUT
    } sha_state_t;

    // Source of the byte that is pushed into the block.
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;
        byte_src_t  byte_sel;
        logic       count_inc;
        logic       load_vars;
        logic       round;
        logic [5:0] round_idx;
        logic       fold;
        logic       emit;
        logic [2:0] idx;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] block_pos;
    } dp_status_t;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] PRE_LEN_POS   = 6'd55;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    // Initial hash value for word i.
    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        unique case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round constant for round r.
    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/sha_strm_dp.sv =====
// Datapath of the stream hasher: schedule window, round variables, chain value and counters.
`timescale 1ns / 1ps

module sha_strm_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                data_byte,
    input  sha_strm_pkg::dp_cmd_t     cmd,
    output sha_strm_pkg::dp_status_t  status,
    output logic                      result_valid,
    output sha_strm_pkg::sha_result_t result
);
    import sha_strm_pkg::*;

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] vars_reg [8];
    logic [31:0] vars_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [63:0] count_reg;
    logic [63:0] count_next;
    logic [5:0]  pos_reg;
    logic [5:0]  pos_next;
    logic        valid_reg;
    sha_result_t result_reg;

    logic [63:0] bit_len;
    logic [7:0]  push_byte;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic        last_emit;

    assign status.block_pos = pos_reg;
    assign result_valid     = valid_reg;
    assign result           = result_reg;

    // Bit length of the message, modulo 2^64.
    assign bit_len   = {count_reg[60:0], 3'b000};
    assign last_emit = cmd.emit && (cmd.idx == LAST_WORD_IDX);

    // Select the byte that enters the block.
    always_comb
    begin
        unique case (cmd.byte_sel)
            SRC_DATA: push_byte = data_byte;
            SRC_MARK: push_byte = PAD_MARK_BYTE;
            SRC_ZERO: push_byte = 8'h00;
            SRC_LEN:  push_byte = bit_len[{~cmd.idx, 3'b000} +: 8];
            default:  push_byte = 8'h00;
        endcase
    end

    // Next schedule word and the two round temporaries.
    assign sched_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign t1 = vars_reg[7] + big_sigma1(vars_reg[4])
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + round_k(cmd.round_idx) + w_reg[0];
    assign t2 = big_sigma0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    // Schedule window: bytes shift in while loading, words shift during rounds.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (cmd.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_next[15] = {w_reg[15][23:0], push_byte};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = sched_new;
        end
    end

    // Round variables a to h.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            vars_next[i] = vars_reg[i];
        end
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
            begin
                vars_next[i] = chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
    end

    // Chain value: fold after each block, back to the initial values after the last word.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chain_next[i] = chain_reg[i];
            if (cmd.fold)
            begin
                chain_next[i] = chain_reg[i] + vars_reg[i];
            end
            else if (last_emit)
            begin
                chain_next[i] = init_hash(3'(i));
            end
        end
    end

    // Byte counters.
    always_comb
    begin
        count_next = count_reg;
        if (last_emit)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + 64'd1;
        end
        pos_next = cmd.push ? pos_reg + 6'd1 : pos_reg;
    end

    // Control registers and chain value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
            count_reg <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            valid_reg <= cmd.emit;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        vars_reg <= vars_next;
        if (cmd.emit)
        begin
            result_reg.digest_word <= chain_reg[cmd.idx];
            result_reg.word_index  <= cmd.idx;
            result_reg.last_word   <= (cmd.idx == LAST_WORD_IDX);
        end
    end

endmodule

// ===== rtl/sha_strm_ctrl.sv =====
// Controller of the stream hasher: intake, padding sequence, rounds and digest output.
`timescale 1ns / 1ps

module sha_strm_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     has_byte,
    input  logic                     end_of_message,
    input  sha_strm_pkg::dp_status_t status,
    output sha_strm_pkg::dp_cmd_t    cmd,
    output logic                     busy
);
    import sha_strm_pkg::*;

    sha_state_t state_reg;
    sha_state_t state_next;
    sha_state_t ret_reg;
    sha_state_t ret_next;
    logic [5:0] round_cnt_reg;
    logic [5:0] round_cnt_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       block_full;

    assign block_full = (status.block_pos == LAST_POS);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            round_cnt_reg <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            round_cnt_reg <= round_cnt_next;
            idx_reg       <= idx_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        round_cnt_next = round_cnt_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.byte_sel   = SRC_DATA;
        cmd.round_idx  = round_cnt_reg;
        cmd.idx        = idx_reg;
        busy           = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (has_byte)
                    begin
                        cmd.push      = 1'b1;
                        cmd.count_inc = 1'b1;
                    end
                    if (has_byte && block_full)
                    begin
                        cmd.load_vars = 1'b1;
                        ret_next      = end_of_message ? ST_PAD_MARK : ST_IDLE;
                        state_next    = ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round      = 1'b1;
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            ST_PAD_MARK:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = SRC_MARK;
                if (block_full)
                begin
                    cmd.load_vars = 1'b1;
                    ret_next      = ST_PAD_ZERO;
                    state_next    = ST_ROUND;
                end
                else if (status.block_pos == PRE_LEN_POS)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = SRC_ZERO;
                if (block_full)
                begin
                    cmd.load_vars = 1'b1;
                    ret_next      = ST_PAD_ZERO;
                    state_next    = ST_ROUND;
                end
                else if (status.block_pos == PRE_LEN_POS)
                begin
                    state_next = ST_PAD_LEN;
                end
            end
            ST_PAD_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = SRC_LEN;
                idx_next     = idx_reg + 3'd1;
                if (block_full)
                begin
                    cmd.load_vars = 1'b1;
                    ret_next      = ST_OUTPUT;
                    state_next    = ST_ROUND;
                end
            end
            ST_OUTPUT:
            begin
                cmd.emit = 1'b1;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == LAST_WORD_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A block is only compressed once all 64 of its bytes are in.
    a_round_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (status.block_pos == 6'd0))
        else $error("rounds running on a partly filled block");

    // The round counter is at zero whenever a new item may enter.
    a_idle_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (round_cnt_reg == 6'd0))
        else $error("round counter not at zero while idle");

    // The length bytes start exactly at byte 56 of the block.
    a_len_position: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD_LEN && idx_reg == 3'd0) |-> (status.block_pos == LEN_POS))
        else $error("length field misplaced");

    // The digest words start from index zero.
    a_output_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD && ret_reg == ST_OUTPUT) |=>
            (state_reg == ST_OUTPUT && idx_reg == 3'd0))
        else $error("digest output does not start at word zero");

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: controller and datapath.
`timescale 1ns / 1ps
//
// Byte-stream SHA-256 hasher. An item (one byte with its has_byte and
// end_of_message flags) is taken at a rising edge where start is high and
// busy is low. An item with has_byte set adds its byte to the message; an
// item with end_of_message set closes the message, with or without a byte.
// An item that neither fills a 64-byte block nor ends the message leaves
// busy low. The item that fills a block keeps busy high while the block
// is compressed: 64 rounds of the single round unit, one per cycle, then
// a fold of the round variables into the chain value.
// On the end item the padding is fed through the same byte path, one byte
// per cycle, up to byte 63 of the last block; with that one or two further
// compressions. Then the eight digest words appear on result for one
// cycle each, marked by result_valid, word 0 first, the first in the cycle
// after the output phase begins. The receiver cannot hold results
// off. After the last word the chain value returns to the initial hash
// values and the next message may start. Reset clears the controller, the
// counters and the chain value at once; no clearing pass is needed.
//
module sha256_stream_hasher (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  sha_strm_pkg::sha_item_t   item,
    output logic                      busy,
    output logic                      result_valid,
    output sha_strm_pkg::sha_result_t result
);
    import sha_strm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller.
    sha_strm_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .has_byte       (item.has_byte),
        .end_of_message (item.end_of_message),
        .status         (status),
        .cmd            (cmd),
        .busy           (busy)
    );

    // Datapath.
    sha_strm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (item.data_byte),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the SHA-256 stream hasher, with its own digest predictor.
`timescale 1ns / 1ps

module tb_top;

    import sha_strm_pkg::*;

    // SHA-256 round constants and initial hash words for the predictor.
    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [0:7][31:0] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam int unsigned RANDOM_ITEMS = 170;
    localparam int unsigned SETTLE_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    sha_item_t   item_bus = '0;
    logic        busy;
    logic        result_valid;
    sha_result_t result_bus;

    // Predictor state: chain value, block buffer and message length in bytes.
    logic [31:0] hash_chain [8];
    logic [7:0]  block_buf [64];
    logic [63:0] msg_len;

    sha_result_t digest_q [$];
    int unsigned err_count = 0;
    int unsigned burst_left = 0;
    int unsigned random_items = 0;

    sha256_stream_hasher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item_bus),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result_bus)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Runs the 64 rounds over the block buffer and folds them into the chain.
    function automatic void compress_buffer();
        logic [31:0] sched [16];
        logic [31:0] v [8];
        logic [31:0] wt, s0, s1, t1, t2, w15, w2;
        for (int j = 0; j < 16; j++)
            sched[j] = {block_buf[4*j], block_buf[4*j+1], block_buf[4*j+2], block_buf[4*j+3]};
        for (int j = 0; j < 8; j++)
            v[j] = hash_chain[j];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                wt = sched[r];
            else
            begin
                w15 = sched[(r - 15) & 15];
                w2  = sched[(r - 2) & 15];
                s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
                s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
                wt  = sched[r & 15] + s0 + sched[(r - 7) & 15] + s1;
                sched[r & 15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_chain[j] = hash_chain[j] + v[j];
    endfunction

    function automatic void clear_message();
        for (int j = 0; j < 8; j++)
            hash_chain[j] = HASH_IV[j];
        msg_len = '0;
    endfunction

    // Absorbs one accepted item; an end item pads, finishes and queues the digest.
    function automatic void absorb_item(input sha_item_t it);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        sha_result_t word;
        if (it.has_byte)
        begin
            block_buf[msg_len[5:0]] = it.data_byte;
            msg_len = msg_len + 64'd1;
            if (msg_len[5:0] == 6'd0)
                compress_buffer();
        end
        if (it.end_of_message)
        begin
            pos = msg_len[5:0];
            bit_len = msg_len << 3;
            block_buf[pos] = PAD_MARK_BYTE;
            for (int j = int'(pos) + 1; j < 64; j++)
                block_buf[j] = 8'h00;
            if (pos >= LEN_POS)
            begin
                compress_buffer();
                for (int j = 0; j < 64; j++)
                    block_buf[j] = 8'h00;
            end
            for (int j = 0; j < 8; j++)
                block_buf[63 - j] = bit_len[8*j +: 8];
            compress_buffer();
            for (int j = 0; j < 8; j++)
            begin
                word.digest_word = hash_chain[j];
                word.word_index  = 3'(j);
                word.last_word   = (j == 7);
                digest_q.push_back(word);
            end
            clear_message();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    // Each result word is compared with the oldest expected word.
    always @(posedge clk)
    begin
        sha_result_t want;
        if (rst_n && result_valid)
        begin
            if (digest_q.size() == 0)
                report_mismatch("digest word with none expected", result_bus.digest_word, '0);
            else
            begin
                want = digest_q.pop_front();
                if (result_bus.digest_word !== want.digest_word)
                    report_mismatch("digest_word", result_bus.digest_word, want.digest_word);
                if (result_bus.word_index !== want.word_index)
                    report_mismatch("word_index", 32'(result_bus.word_index),
                                    32'(want.word_index));
                if (result_bus.last_word !== want.last_word)
                    report_mismatch("last_word", 32'(result_bus.last_word),
                                    32'(want.last_word));
            end
        end
    end

    // Holds one item on the bus until it is taken; called and returns at a falling edge.
    task automatic push_item(input sha_item_t it);
        start = 1'b1;
        item_bus = it;
        do
            @(posedge clk);
        while (busy);
        absorb_item(it);
        @(negedge clk);
        start = 1'b0;
    endtask

    // Sends in bursts of random length with random gaps, now and then long ones.
    task automatic send_item(input sha_item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(20, 90);
                default: gap = $urandom_range(1, 8);
            endcase
            item_bus.data_byte = 8'($urandom);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push_item(it);
    endtask

    function automatic sha_item_t make_item(input logic [7:0] data, input bit has,
                                            input bit fin);
        sha_item_t it;
        it.data_byte = data;
        it.has_byte = has;
        it.end_of_message = fin;
        return it;
    endfunction

    // Sends one message of random bytes, closed on its last byte or by an empty end item.
    task automatic send_message(input int unsigned len, input bit end_on_byte,
                                input bit with_noise);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (with_noise && $urandom_range(0, 9) == 0)
                send_item(make_item(8'($urandom), 1'b0, 1'b0));
            send_item(make_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1)));
            random_items++;
        end
        if (!end_on_byte || len == 0)
        begin
            send_item(make_item(8'($urandom), 1'b0, 1'b1));
            random_items++;
        end
    endtask

    // Holds the sender back until every expected digest word has come out.
    task automatic wait_for_digests();
        while (digest_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Empty messages: an end item with no byte, twice in a row, the ignored byte set.
    task automatic test_empty_message();
        push_item(make_item(8'hff, 1'b0, 1'b1));
        push_item(make_item(8'h00, 1'b0, 1'b1));
        wait_for_digests();
    endtask

    // Short directed messages: "abc", byte extremes and items that carry nothing.
    task automatic test_short_messages();
        push_item(make_item(8'h61, 1'b1, 1'b0));
        push_item(make_item(8'h62, 1'b1, 1'b0));
        push_item(make_item(8'h63, 1'b1, 1'b1));
        push_item(make_item(8'h00, 1'b1, 1'b0));
        push_item(make_item(8'hff, 1'b0, 1'b0));
        push_item(make_item(8'hff, 1'b1, 1'b0));
        push_item(make_item(8'h00, 1'b0, 1'b0));
        push_item(make_item(8'h5a, 1'b0, 1'b1));
        push_item(make_item(8'hff, 1'b1, 1'b1));
        wait_for_digests();
    endtask

    // Block boundaries: a full block closed on its last byte, then the two-block padding case.
    task automatic test_block_boundaries();
        send_message(64, 1'b1, 1'b1);
        send_message(56, 1'b1, 1'b0);
        wait_for_digests();
    endtask

    // Random messages: the longest single-block padding first, then short ones.
    task automatic test_random_messages();
        send_message(55, 1'b0, 1'b1);
        while (random_items < RANDOM_ITEMS)
            send_message($urandom_range(0, 12), 1'($urandom), 1'b1);
    endtask

    initial
    begin
        clear_message();
        for (int j = 0; j < 64; j++)
            block_buf[j] = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_message();
        test_short_messages();
        test_block_boundaries();
        test_random_messages();

        wait_for_digests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog for a hung handshake or missing digest words.
    initial
    begin
        #2_000_000;
        $display("timeout with %0d digest words outstanding", digest_q.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
